FILE: rtl/core/affine_warp_bilinear_core_macros.svh
// Assertion helpers for the affine warp core.
`ifndef AFFINE_WARP_BILINEAR_CORE_MACROS_SVH
`define AFFINE_WARP_BILINEAR_CORE_MACROS_SVH
`ifndef SYNTH
`define AWB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("affine warp core: implication check failed");
`define AWB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("affine warp core: next-cycle check failed");
`else
`define AWB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define AWB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

FILE: rtl/core/aw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aw_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PIX_W       = 8;
  localparam int SRC_W       = 9;
  localparam int DST_W       = 12;
  localparam int COEF_W      = 32;
  localparam int LAST_W      = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = COEF_W + DST_W + 1;
  localparam int MAP_W       = 48;
  localparam int WGT_W       = 2 * FRAC_BITS + 1;
  localparam int CPROD_W     = WGT_W + PIX_W;
  localparam int ACC_W       = CPROD_W + 2;
  localparam int BANK_ADDR_W = 2 * (SRC_W - 1);
  localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;
  localparam int PIPE_LAT    = 7;
  localparam logic [SRC_W-1:0] SRC_LAST = {SRC_W{1'b1}};

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_CC = 3'd0,
    REG_COEF_CR = 3'd1,
    REG_OFF_COL = 3'd2,
    REG_COEF_RC = 3'd3,
    REG_COEF_RR = 3'd4,
    REG_OFF_ROW = 3'd5,
    REG_LAST    = 3'd6,
    REG_CLAMP   = 3'd7
  } cfg_reg_t;

  localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(1 << FRAC_BITS);
  localparam logic [LAST_W-1:0] LAST_RESET = 25'h1FF01FF;

endpackage
`default_nettype wire

FILE: rtl/core/affine_warp_bilinear_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "affine_warp_bilinear_core_macros.svh"
// Affine warp core with bilinear blend. Write beats (in_operation = 0) store one
// 24-bit pixel into the source image; request beats (in_operation = 1) map a
// destination column and row through the Q16.16 inverse coefficients and
// return one blended pixel, marked by out_valid for a single cycle. The receiver
// cannot stall: it must take every result beat as it appears. busy stays low, so
// one beat enters every cycle. The rate is set by the source store, split into
// four banks by column and row parity so that the four neighbours come from one
// read port each cycle. Writes commit at the same pipeline stage as the reads,
// so every request sees exactly the writes accepted before it. cfg_ready stays
// high and a register write lands at once: write configuration only while no
// beat is in flight.
module affine_warp_bilinear_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire                             in_operation,
  input  wire  [aw_pkg::SRC_W-1:0]        in_src_col,
  input  wire  [aw_pkg::SRC_W-1:0]        in_src_row,
  input  wire  [aw_pkg::PIX_W-1:0]        in_pixel_ch0,
  input  wire  [aw_pkg::PIX_W-1:0]        in_pixel_ch1,
  input  wire  [aw_pkg::PIX_W-1:0]        in_pixel_ch2,
  input  wire  [aw_pkg::DST_W-1:0]        in_dst_col,
  input  wire  [aw_pkg::DST_W-1:0]        in_dst_row,
  output logic                            out_valid,
  output logic [aw_pkg::PIX_W-1:0]        out_ch0,
  output logic [aw_pkg::PIX_W-1:0]        out_ch1,
  output logic [aw_pkg::PIX_W-1:0]        out_ch2,
  output logic                            out_in_bounds,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [aw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [aw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aw_pkg::*;

  // configuration registers
  logic signed [COEF_W-1:0] cfg_cc_r, cfg_cr_r, cfg_oc_r;
  logic signed [COEF_W-1:0] cfg_rc_r, cfg_rr_r, cfg_or_r;
  logic [LAST_W-1:0]        cfg_last_r;
  logic                     cfg_clamp_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cc_r    <= COEF_UNITY;
      cfg_cr_r    <= '0;
      cfg_oc_r    <= '0;
      cfg_rc_r    <= '0;
      cfg_rr_r    <= COEF_UNITY;
      cfg_or_r    <= '0;
      cfg_last_r  <= LAST_RESET;
      cfg_clamp_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COEF_CC: cfg_cc_r    <= cfg_data;
        REG_COEF_CR: cfg_cr_r    <= cfg_data;
        REG_OFF_COL: cfg_oc_r    <= cfg_data;
        REG_COEF_RC: cfg_rc_r    <= cfg_data;
        REG_COEF_RR: cfg_rr_r    <= cfg_data;
        REG_OFF_ROW: cfg_or_r    <= cfg_data;
        REG_LAST:    cfg_last_r  <= cfg_data[LAST_W-1:0];
        REG_CLAMP:   cfg_clamp_r <= cfg_data[0];
      endcase
    end
  end

  // stage valids and write-side payload carried down to the store stage
  logic                  s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic                  s1_req_r, s2_req_r, s3_req_r;
  logic [SRC_W-1:0]      s1_wcol_r, s2_wcol_r, s3_wcol_r;
  logic [SRC_W-1:0]      s1_wrow_r, s2_wrow_r, s3_wrow_r;
  logic [3*PIX_W-1:0]    s1_wpix_r, s2_wpix_r, s3_wpix_r;
  logic [DST_W-1:0]      s1_dcol_r, s1_drow_r;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= (op_t'(in_operation) == OP_REQUEST);
    s1_wcol_r <= in_src_col;
    s1_wrow_r <= in_src_row;
    s1_wpix_r <= {in_pixel_ch2, in_pixel_ch1, in_pixel_ch0};
    s1_dcol_r <= in_dst_col;
    s1_drow_r <= in_dst_row;
    s2_req_r  <= s1_req_r;
    s2_wcol_r <= s1_wcol_r;
    s2_wrow_r <= s1_wrow_r;
    s2_wpix_r <= s1_wpix_r;
    s3_req_r  <= s2_req_r;
    s3_wcol_r <= s2_wcol_r;
    s3_wrow_r <= s2_wrow_r;
    s3_wpix_r <= s2_wpix_r;
  end

  // stage 2: four coefficient products
  logic signed [PROD_W-1:0] s2_pcc_r, s2_pcr_r, s2_prc_r, s2_prr_r;
  logic signed [DST_W:0]    s1_dc_s, s1_dr_s;
  assign s1_dc_s = $signed({1'b0, s1_dcol_r});
  assign s1_dr_s = $signed({1'b0, s1_drow_r});

  always_ff @(posedge clk) begin
    s2_pcc_r <= cfg_cc_r * s1_dc_s;
    s2_pcr_r <= cfg_cr_r * s1_dr_s;
    s2_prc_r <= cfg_rc_r * s1_dc_s;
    s2_prr_r <= cfg_rr_r * s1_dr_s;
  end

  // stage 3: mapped source point, exact
  logic signed [MAP_W-1:0] s3_u_r, s3_v_r;
  always_ff @(posedge clk) begin
    s3_u_r <= MAP_W'(s2_pcc_r) + MAP_W'(s2_pcr_r) + MAP_W'(cfg_oc_r);
    s3_v_r <= MAP_W'(s2_prc_r) + MAP_W'(s2_prr_r) + MAP_W'(cfg_or_r);
  end

  // clamp, bounds test, neighbour addressing
  logic [SRC_W-1:0]        last_col, last_row;
  logic signed [MAP_W-1:0] umax, vmax, u_cl, v_cl;
  logic                    s3_inside;
  logic [SRC_W-1:0]        left, top;
  logic [SRC_W:0]          left_p1, top_p1;
  logic [SRC_W:0]          col_sel [2];
  logic [SRC_W:0]          row_sel [2];
  logic [BANK_ADDR_W-1:0]  raddr [4];

  always_comb begin
    last_col = (cfg_last_r[15:0] > 16'(SRC_LAST)) ? SRC_LAST : cfg_last_r[SRC_W-1:0];
    last_row = cfg_last_r[16 +: SRC_W];
    umax = $signed(MAP_W'({last_col, {FRAC_BITS{1'b0}}}));
    vmax = $signed(MAP_W'({last_row, {FRAC_BITS{1'b0}}}));
    u_cl = s3_u_r;
    v_cl = s3_v_r;
    if (cfg_clamp_r) begin
      if (u_cl < 0)    u_cl = '0;
      if (u_cl > umax) u_cl = umax;
      if (v_cl < 0)    v_cl = '0;
      if (v_cl > vmax) v_cl = vmax;
    end
    s3_inside = !(u_cl < 0 || v_cl < 0 || u_cl > umax || v_cl > vmax);
    left    = u_cl[FRAC_BITS +: SRC_W];
    top     = v_cl[FRAC_BITS +: SRC_W];
    left_p1 = {1'b0, left} + 1'b1;
    top_p1  = {1'b0, top} + 1'b1;
    // each parity bank takes whichever of the two columns (rows) has its parity
    for (int p = 0; p < 2; p++) begin
      col_sel[p] = (left[0] == 1'(p)) ? {1'b0, left} : left_p1;
      row_sel[p] = (top[0] == 1'(p))  ? {1'b0, top}  : top_p1;
    end
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {row_sel[b/2][SRC_W-1:1], col_sel[b%2][SRC_W-1:1]};
    end
  end

  // source store: four parity banks, one write port shared, one read port each
  logic [3*PIX_W-1:0]      src_mem_r [4][BANK_DEPTH];
  logic [3*PIX_W-1:0]      rd_r [4];
  logic                    s3_wr_en;
  logic [1:0]              wbank;
  logic [BANK_ADDR_W-1:0]  waddr;

  assign s3_wr_en = s3_vld_r && !s3_req_r;
  assign wbank    = {s3_wrow_r[0], s3_wcol_r[0]};
  assign waddr    = {s3_wrow_r[SRC_W-1:1], s3_wcol_r[SRC_W-1:1]};

  always_ff @(posedge clk) begin
    if (s3_wr_en) begin
      src_mem_r[wbank][waddr] <= s3_wpix_r;
    end
    for (int b = 0; b < 4; b++) begin
      rd_r[b] <= src_mem_r[b][raddr[b]];
    end
  end

  // stage 4: fractions and bank selectors alongside the read data
  logic                 s4_inside_r, s4_lpar_r, s4_tpar_r;
  logic [FRAC_BITS-1:0] s4_fu_r, s4_fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r && s3_req_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_inside_r <= s3_inside;
    s4_lpar_r   <= left[0];
    s4_tpar_r   <= top[0];
    s4_fu_r     <= u_cl[FRAC_BITS-1:0];
    s4_fv_r     <= v_cl[FRAC_BITS-1:0];
  end

  // pick the neighbours; on an exact grid line reuse the left or top pixel
  logic [3*PIX_W-1:0] p00, p01, p10, p11;
  logic               fu_nz, fv_nz;
  logic [FRAC_BITS:0] one_m_fu, one_m_fv;

  always_comb begin
    fu_nz = |s4_fu_r;
    fv_nz = |s4_fv_r;
    p00 = rd_r[{s4_tpar_r, s4_lpar_r}];
    p01 = fu_nz ? rd_r[{s4_tpar_r, ~s4_lpar_r}] : p00;
    p10 = fv_nz ? rd_r[{~s4_tpar_r, s4_lpar_r}] : p00;
    if (fu_nz && fv_nz) begin
      p11 = rd_r[{~s4_tpar_r, ~s4_lpar_r}];
    end else if (fu_nz) begin
      p11 = p01;
    end else begin
      p11 = p10;
    end
    one_m_fu = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, s4_fu_r};
    one_m_fv = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, s4_fv_r};
  end

  // stage 5: weights and pixels
  logic [WGT_W-1:0]   s5_w_r [4];
  logic [3*PIX_W-1:0] s5_p_r [4];
  logic               s5_inside_r;

  always_ff @(posedge clk) begin
    s5_w_r[0]   <= WGT_W'(one_m_fv) * WGT_W'(one_m_fu);
    s5_w_r[1]   <= WGT_W'(one_m_fv) * WGT_W'({1'b0, s4_fu_r});
    s5_w_r[2]   <= WGT_W'({1'b0, s4_fv_r}) * WGT_W'(one_m_fu);
    s5_w_r[3]   <= WGT_W'({1'b0, s4_fv_r}) * WGT_W'({1'b0, s4_fu_r});
    s5_p_r[0]   <= p00;
    s5_p_r[1]   <= p01;
    s5_p_r[2]   <= p10;
    s5_p_r[3]   <= p11;
    s5_inside_r <= s4_inside_r;
  end

  // stage 6: weighted channel terms
  logic [CPROD_W-1:0] s6_t_r [3][4];
  logic               s6_inside_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        s6_t_r[c][k] <= s5_w_r[k] * CPROD_W'(s5_p_r[k][c*PIX_W +: PIX_W]);
      end
    end
    s6_inside_r <= s5_inside_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      out_valid <= s6_vld_r;
    end
  end

  // result beat: sum, truncate, zero when outside
  logic [ACC_W-1:0] acc [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(s6_t_r[c][0]) + ACC_W'(s6_t_r[c][1])
             + ACC_W'(s6_t_r[c][2]) + ACC_W'(s6_t_r[c][3]);
    end
  end

  always_ff @(posedge clk) begin
    out_ch0       <= s6_inside_r ? acc[0][2*FRAC_BITS +: PIX_W] : '0;
    out_ch1       <= s6_inside_r ? acc[1][2*FRAC_BITS +: PIX_W] : '0;
    out_ch2       <= s6_inside_r ? acc[2][2*FRAC_BITS +: PIX_W] : '0;
    out_in_bounds <= s6_inside_r;
  end

  `AWB_ASSERT_IMPL(a_result_latency, clk, rst_n, out_valid,
                   $past(start && !busy && in_operation, PIPE_LAT))
  `AWB_ASSERT_IMPL(a_outside_zero, clk, rst_n, out_valid && !out_in_bounds,
                   out_ch0 == '0 && out_ch1 == '0 && out_ch2 == '0)
  `AWB_ASSERT_IMPL(a_clamp_inside, clk, rst_n, s3_vld_r && s3_req_r && cfg_clamp_r,
                   s3_inside)
  `AWB_ASSERT_NEXT(a_write_no_result, clk, rst_n, s3_wr_en, !s4_vld_r)

endmodule
`default_nettype wire

FILE: dv/affine_warp_bilinear_core_tb.sv
`timescale 1ns / 1ps
module affine_warp_bilinear_core_tb;
  import aw_pkg::*;

  localparam int STORE_COLS = 512;
  localparam int STORE_ROWS = 512;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [PIX_W-1:0] ch0;
    logic [PIX_W-1:0] ch1;
    logic [PIX_W-1:0] ch2;
    logic             in_bnd;
  } warp_pixel_t;

  // Scoreboard: shadow registers, shadow source image and the queue of
  // blended pixels still owed by the block.
  class warp_scoreboard;
    logic [COEF_W-1:0] coef_cc, coef_cr, off_col, coef_rc, coef_rr, off_row;
    logic [LAST_W-1:0] last_idx;
    logic              clamp_on;
    logic [23:0]       image [STORE_COLS*STORE_ROWS];
    bit                written [STORE_COLS*STORE_ROWS];
    warp_pixel_t       owed_pixels[$];
    int                n_errors;
    int                n_checked;

    function void reset_regs();
      coef_cc = COEF_UNITY;
      coef_cr = '0;
      off_col = '0;
      coef_rc = '0;
      coef_rr = COEF_UNITY;
      off_row = '0;
      last_idx = LAST_RESET;
      clamp_on = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COEF_CC: coef_cc = data;
        REG_COEF_CR: coef_cr = data;
        REG_OFF_COL: off_col = data;
        REG_COEF_RC: coef_rc = data;
        REG_COEF_RR: coef_rr = data;
        REG_OFF_ROW: off_row = data;
        REG_LAST:    last_idx = data[LAST_W-1:0];
        REG_CLAMP:   clamp_on = data[0];
        default: ;
      endcase
    endfunction

    // Map a destination point to the source; returns 0 when it lands outside.
    function bit map_point(logic [DST_W-1:0] dc, logic [DST_W-1:0] dr,
                           output longint u, output longint v);
      longint umax, vmax;
      int lc, lr;
      lc = last_idx[15:0];
      lr = last_idx[24:16];
      // saturate an oversized last index to the store size
      if (lc > STORE_COLS - 1) lc = STORE_COLS - 1;
      if (lr > STORE_ROWS - 1) lr = STORE_ROWS - 1;
      umax = longint'(lc) << FRAC_BITS;
      vmax = longint'(lr) << FRAC_BITS;
      u = longint'($signed(coef_cc)) * longint'(dc) +
          longint'($signed(coef_cr)) * longint'(dr) + longint'($signed(off_col));
      v = longint'($signed(coef_rc)) * longint'(dc) +
          longint'($signed(coef_rr)) * longint'(dr) + longint'($signed(off_row));
      if (clamp_on) begin
        if (u < 0) u = 0;
        if (u > umax) u = umax;
        if (v < 0) v = 0;
        if (v > vmax) v = vmax;
      end
      return !(u < 0 || v < 0 || u > umax || v > vmax);
    endfunction

    // True when a request would touch a store entry never written.
    function bit hits_unwritten(logic [DST_W-1:0] dc, logic [DST_W-1:0] dr);
      longint u, v;
      int l, t, r, b;
      if (!map_point(dc, dr, u, v)) return 0;
      l = int'(u >>> FRAC_BITS);
      t = int'(v >>> FRAC_BITS);
      r = l + ((u[FRAC_BITS-1:0] != 0) ? 1 : 0);
      b = t + ((v[FRAC_BITS-1:0] != 0) ? 1 : 0);
      return !(written[t*STORE_COLS+l] && written[t*STORE_COLS+r] &&
               written[b*STORE_COLS+l] && written[b*STORE_COLS+r]);
    endfunction

    function warp_pixel_t blend(logic [DST_W-1:0] dc, logic [DST_W-1:0] dr);
      longint u, v;
      longint unsigned one, fu, fv, w00, w01, w10, w11, acc;
      int l, t, r, b;
      logic [23:0] p00, p01, p10, p11;
      logic [PIX_W-1:0] chv [3];
      warp_pixel_t res;
      res = '0;
      if (!map_point(dc, dr, u, v)) return res;
      one = 64'd1 << FRAC_BITS;
      fu = longint'(u[FRAC_BITS-1:0]);
      fv = longint'(v[FRAC_BITS-1:0]);
      l = int'(u >>> FRAC_BITS);
      t = int'(v >>> FRAC_BITS);
      r = l + ((fu != 0) ? 1 : 0);
      b = t + ((fv != 0) ? 1 : 0);
      w00 = (one - fv) * (one - fu);
      w01 = (one - fv) * fu;
      w10 = fv * (one - fu);
      w11 = fv * fu;
      p00 = image[t*STORE_COLS+l];
      p01 = image[t*STORE_COLS+r];
      p10 = image[b*STORE_COLS+l];
      p11 = image[b*STORE_COLS+r];
      for (int ch = 0; ch < 3; ch++) begin
        acc = w00 * p00[ch*8 +: 8] + w01 * p01[ch*8 +: 8] +
              w10 * p10[ch*8 +: 8] + w11 * p11[ch*8 +: 8];
        chv[ch] = acc[2*FRAC_BITS +: 8];
      end
      res.ch0 = chv[0];
      res.ch1 = chv[1];
      res.ch2 = chv[2];
      res.in_bnd = 1'b1;
      return res;
    endfunction

    function void note_beat(op_t op, logic [SRC_W-1:0] sc, logic [SRC_W-1:0] sr,
                            logic [23:0] pix, logic [DST_W-1:0] dc,
                            logic [DST_W-1:0] dr);
      if (op == OP_WRITE) begin
        image[sr*STORE_COLS+sc] = pix;
        written[sr*STORE_COLS+sc] = 1'b1;
      end else begin
        owed_pixels.push_back(blend(dc, dr));
      end
    endfunction

    function void check_pixel(warp_pixel_t got);
      warp_pixel_t want;
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        n_errors++;
        return;
      end
      want = owed_pixels.pop_front();
      n_checked++;
      if (got.ch0 != want.ch0) begin
        $display("%0t: out_ch0 expected %0d actual %0d", $time, want.ch0, got.ch0);
        n_errors++;
      end
      if (got.ch1 != want.ch1) begin
        $display("%0t: out_ch1 expected %0d actual %0d", $time, want.ch1, got.ch1);
        n_errors++;
      end
      if (got.ch2 != want.ch2) begin
        $display("%0t: out_ch2 expected %0d actual %0d", $time, want.ch2, got.ch2);
        n_errors++;
      end
      if (got.in_bnd != want.in_bnd) begin
        $display("%0t: out_in_bounds expected %0d actual %0d", $time, want.in_bnd,
                 got.in_bnd);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_operation;
  logic [SRC_W-1:0]      in_src_col, in_src_row;
  logic [PIX_W-1:0]      in_pixel_ch0, in_pixel_ch1, in_pixel_ch2;
  logic [DST_W-1:0]      in_dst_col, in_dst_row;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_ch0, out_ch1, out_ch2;
  logic                  out_in_bounds;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  warp_scoreboard sb;
  bit gaps_on;
  int n_writes, n_requests, n_phases, stall_cycles;

  affine_warp_bilinear_core dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Compare every result beat; the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_pixel('{out_ch0, out_ch1, out_ch2, out_in_bounds});
  end

  // Watchdog: give up after a long stretch with no beat on any channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("affine_warp_bilinear_core_tb: errors");
      $finish;
    end
  end

  // Drive one beat and hold it until taken; optionally drop start for a burst.
  task automatic drive_beat(op_t op, logic [SRC_W-1:0] sc, logic [SRC_W-1:0] sr,
                            logic [23:0] pix, logic [DST_W-1:0] dc,
                            logic [DST_W-1:0] dr);
    start <= 1'b1;
    in_operation <= op;
    in_src_col <= sc;
    in_src_row <= sr;
    in_pixel_ch0 <= pix[7:0];
    in_pixel_ch1 <= pix[15:8];
    in_pixel_ch2 <= pix[23:16];
    in_dst_col <= dc;
    in_dst_row <= dr;
    do @(posedge clk); while (busy);
    sb.note_beat(op, sc, sr, pix, dc, dr);
    if (op == OP_WRITE) n_writes++;
    else n_requests++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic write_pixel(int c, int r);
    drive_beat(OP_WRITE, SRC_W'(c), SRC_W'(r), 24'($urandom),
               DST_W'($urandom), DST_W'($urandom));
  endtask

  // Request only where every neighbour is known; skip the point otherwise.
  task automatic request_pixel(int dc, int dr);
    if (!sb.hits_unwritten(DST_W'(dc), DST_W'(dr)))
      drive_beat(OP_REQUEST, SRC_W'($urandom), SRC_W'($urandom), 24'($urandom),
                 DST_W'(dc), DST_W'(dr));
  endtask

  // Hold the sender until every owed pixel is out, then let the pipe empty.
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic set_warp(int cc, int cr, int oc, int rc, int rr, int orow,
                          logic [LAST_W-1:0] last, bit clamp);
    drain();
    cfg_write(REG_COEF_CC, cc);
    cfg_write(REG_COEF_CR, cr);
    cfg_write(REG_OFF_COL, oc);
    cfg_write(REG_COEF_RC, rc);
    cfg_write(REG_COEF_RR, rr);
    cfg_write(REG_OFF_ROW, orow);
    cfg_write(REG_LAST, CFG_DATA_W'(last));
    cfg_write(REG_CLAMP, CFG_DATA_W'(clamp));
    n_phases++;
  endtask

  // Random requests aimed near the two filled windows, with some far away, and a few rewrites of the top-left window.
  task automatic random_requests(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        request_pixel($urandom_range(0, 40), $urandom_range(0, 40));
      else if (sel < 7)
        request_pixel($urandom_range(470, 540), $urandom_range(470, 540));
      else if (sel < 9)
        request_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        write_pixel($urandom_range(0, 15), $urandom_range(0, 15));
    end
  endtask

  function automatic int rnd_range(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  initial begin
    sb = new();
    sb.reset_regs();
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_WRITE;
    in_src_col = '0;
    in_src_row = '0;
    in_pixel_ch0 = '0;
    in_pixel_ch1 = '0;
    in_pixel_ch2 = '0;
    in_dst_col = '0;
    in_dst_row = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF_CC;
    cfg_data = '0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the top-left and bottom-right windows; extreme pixels at corners.
    drive_beat(OP_WRITE, 0, 0, 24'h000000, '0, '0);
    drive_beat(OP_WRITE, SRC_LAST, SRC_LAST, 24'hFFFFFF, '1, '1);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) begin
        if (r + c != 0) write_pixel(c, r);
        if (r + c != 30) write_pixel(496 + c, 496 + r);
      end

    // Directed requests at reset settings: identity map over the full store.
    request_pixel(0, 0);
    request_pixel(15, 15);
    request_pixel(511, 511);
    request_pixel(500, 503);
    request_pixel(512, 0);
    request_pixel(0, 4095);
    request_pixel(4095, 4095);
    request_pixel(511, 512);

    // Half scale with fractional offsets and a small shear; last index 15.
    set_warp(32'h8000, 32'h1234, 32'h3000, -32'sh800, 32'h8000, 32'h1800,
             25'h000F_000F, 1'b0);
    request_pixel(0, 0);
    request_pixel(30, 30);
    request_pixel(31, 31);
    request_pixel(2, 4095);
    random_requests(120);

    // Extreme coefficients with clamping: every point pinned to a corner.
    set_warp(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h7FFFFFFF, 32'h7FFFFFFF, 25'h000F_000F, 1'b1);
    request_pixel(0, 0);
    request_pixel(4095, 0);
    request_pixel(0, 4095);
    request_pixel(4095, 4095);
    random_requests(60);

    // The extremes swapped and unclamped: every point lands outside.
    set_warp(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h80000000, 32'h80000000, 25'h000F_000F, 1'b0);
    random_requests(40);

    // Oversized last index saturates; shift by half a pixel and clamp.
    set_warp(32'h10000, 0, -32'sh8000, 0, 32'h10000, -32'sh8000,
             25'h1FF_FFFF, 1'b1);
    request_pixel(0, 0);
    request_pixel(4095, 4095);
    random_requests(150);

    // Random mild warps until the run has its bulk of items.
    while (n_writes + n_requests < 1200) begin
      set_warp(rnd_range(-32'sh20000, 32'sh20000), rnd_range(-32'sh8000, 32'sh8000),
               rnd_range(-32'sh100000, 32'sh100000), rnd_range(-32'sh8000, 32'sh8000),
               rnd_range(-32'sh20000, 32'sh20000), rnd_range(-32'sh100000, 32'sh100000),
               $urandom_range(0, 1) ? 25'h000F_000F : LAST_RESET,
               $urandom_range(0, 1));
      random_requests(100);
    end

    // Final stretch at full rate: unit scale with fractional offsets near both windows, no gaps.
    set_warp(32'h10000, 0, 32'h4000, 0, 32'h10000, 32'hC000, LAST_RESET, 1'b0);
    gaps_on = 1'b0;
    random_requests(300);

    drain();
    $display("covered %0d pixel writes, %0d requests, %0d register settings",
             n_writes, n_requests, n_phases);
    $display("%0d blended pixels compared, %0d mismatches", sb.n_checked,
             sb.n_errors);
    if (sb.n_errors == 0 && sb.owed_pixels.size() == 0)
      $display("affine_warp_bilinear_core_tb: clean");
    else
      $display("affine_warp_bilinear_core_tb: errors");
    $finish;
  end

endmodule
